### src/cbm_pkg.sv
// Shared types, codes and decode functions for the cartridge bank mapper.
// Used by cbm_regs, cbm_decode and cartridge_bank_mapper_top; depends on nothing.
`default_nettype none

package cbm_pkg;

	typedef enum logic [3:0] {
		REGION_ROM  = 4'd0,
		REGION_CRAM = 4'd1,
		REGION_VRAM = 4'd2,
		REGION_WRAM = 4'd3,
		REGION_OAM  = 4'd4,
		REGION_IO   = 4'd5,
		REGION_HRAM = 4'd6,
		REGION_IE   = 4'd7,
		REGION_OPEN = 4'd8,
		REGION_CTRL = 4'd9
	} region_t;

	typedef enum logic [2:0] {
		MAPPER_NONE,
		MAPPER_MBC1,
		MAPPER_MBC2,
		MAPPER_MBC3,
		MAPPER_MBC5
	} mapper_t;

	// Control-space register groups, selected by address bits 14:13.
	typedef enum logic [1:0] {
		CTRL_RAM_ENABLE = 2'd0,
		CTRL_ROM_BANK   = 2'd1,
		CTRL_UPPER_BANK = 2'd2,
		CTRL_MODE       = 2'd3
	} ctrl_sel_t;

	localparam int unsigned CMD_WIDTH   = 1;
	localparam int unsigned ADDR_WIDTH  = 16;
	localparam int unsigned DATA_WIDTH  = 8;
	localparam int unsigned OFFS_WIDTH  = 22;
	localparam int unsigned TYPE_WIDTH  = 8;

	localparam logic [DATA_WIDTH-1:0] OPEN_BUS_BYTE = 8'hFF;
	localparam logic [3:0]            RAM_KEY       = 4'hA;

	localparam logic [ADDR_WIDTH-1:0] OAM_BASE  = 16'hFE00;
	localparam logic [ADDR_WIDTH-1:0] OAM_LAST  = 16'hFE9F;
	localparam logic [ADDR_WIDTH-1:0] IO_BASE   = 16'hFF00;
	localparam logic [ADDR_WIDTH-1:0] IO_LAST   = 16'hFF7F;
	localparam logic [ADDR_WIDTH-1:0] HRAM_BASE = 16'hFF80;
	localparam logic [ADDR_WIDTH-1:0] HRAM_LAST = 16'hFFFE;
	localparam logic [ADDR_WIDTH-1:0] IE_ADDR   = 16'hFFFF;

	typedef struct packed {
		logic [7:0] rom_bank;
		logic [1:0] ram_bank;
		logic       rom_banking_mode;
		logic       ram_enable;
	} bank_state_t;

	typedef struct packed {
		logic                  command;
		logic [ADDR_WIDTH-1:0] address;
		logic [DATA_WIDTH-1:0] write_data;
	} access_t;

	typedef struct packed {
		region_t               region;
		logic [OFFS_WIDTH-1:0] offset;
		logic                  write_enable;
		logic [DATA_WIDTH-1:0] out_data;
	} result_t;

	function automatic mapper_t mapper_kind(input logic [TYPE_WIDTH-1:0] hdr_type);
		mapper_t kind;
		unique case (hdr_type) inside
			8'h01, 8'h02, 8'h03:                              kind = MAPPER_MBC1;
			8'h05, 8'h06:                                     kind = MAPPER_MBC2;
			8'h0B, 8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11,
			8'h12, 8'h13:                                     kind = MAPPER_MBC3;
			8'h19, 8'h1A, 8'h1B:                              kind = MAPPER_MBC5;
			default:                                          kind = MAPPER_NONE;
		endcase
		return kind;
	endfunction

	function automatic logic has_ram(input logic [TYPE_WIDTH-1:0] hdr_type);
		logic ram;
		unique case (hdr_type) inside
			8'h02, 8'h03, 8'h12, 8'h13, 8'h19, 8'h1A, 8'h1B: ram = 1'b1;
			default:                                          ram = 1'b0;
		endcase
		return ram;
	endfunction

endpackage

`default_nettype wire

### src/cbm_regs.sv
// Mapper register file: cartridge type and the bank state updated by control writes.
// Depends on cbm_pkg.
`default_nettype none

module cbm_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [cbm_pkg::TYPE_WIDTH-1:0] cfg_wr_data,
	input  wire logic                           upd_en,
	input  wire cbm_pkg::access_t               acc,
	output cbm_pkg::bank_state_t                state
);

	logic [cbm_pkg::TYPE_WIDTH-1:0] hdr_type_q;
	cbm_pkg::bank_state_t           state_q;
	cbm_pkg::bank_state_t           state_d;
	cbm_pkg::mapper_t               kind;
	cbm_pkg::ctrl_sel_t             sel;
	logic                           ram_present;
	logic                           ctrl_wr;
	logic [4:0]                     low5;
	logic [6:0]                     low7;
	logic [cbm_pkg::DATA_WIDTH-1:0] data;

	assign kind        = cbm_pkg::mapper_kind(hdr_type_q);
	assign ram_present = cbm_pkg::has_ram(hdr_type_q);
	assign ctrl_wr     = upd_en && acc.command && !acc.address[15];
	assign sel         = cbm_pkg::ctrl_sel_t'(acc.address[14:13]);
	assign data        = acc.write_data;
	assign low5        = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
	assign low7        = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];

	always_comb begin
		state_d = state_q;
		unique case (sel)
			cbm_pkg::CTRL_RAM_ENABLE: begin
				if (kind != cbm_pkg::MAPPER_NONE && ram_present) begin
					state_d.ram_enable = (data[3:0] == cbm_pkg::RAM_KEY);
				end
			end
			cbm_pkg::CTRL_ROM_BANK: begin
				if (kind == cbm_pkg::MAPPER_MBC1) begin
					state_d.rom_bank = {state_q.rom_bank[7:5], low5};
				end else if (kind == cbm_pkg::MAPPER_MBC3) begin
					state_d.rom_bank = {state_q.rom_bank[7], low7};
				end
			end
			cbm_pkg::CTRL_UPPER_BANK: begin
				if (kind == cbm_pkg::MAPPER_MBC1) begin
					if (state_q.rom_banking_mode) begin
						state_d.rom_bank = {state_q.rom_bank[7], data[1:0], state_q.rom_bank[4:0]};
					end else begin
						state_d.ram_bank = data[1:0];
					end
				end else if (kind == cbm_pkg::MAPPER_MBC3) begin
					if (data[7:2] == 6'd0) begin
						state_d.ram_bank = data[1:0];
					end
				end
			end
			cbm_pkg::CTRL_MODE: begin
				if (kind == cbm_pkg::MAPPER_MBC1) begin
					state_d.rom_banking_mode = !data[0];
					if (!data[0]) begin
						state_d.ram_bank = 2'd0;
					end
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_type_q                 <= '0;
			state_q.rom_bank           <= 8'd1;
			state_q.ram_bank           <= 2'd0;
			state_q.rom_banking_mode   <= 1'b0;
			state_q.ram_enable         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				hdr_type_q <= cfg_wr_data;
			end
			if (ctrl_wr) begin
				state_q <= state_d;
			end
		end
	end

	assign state = state_q;

endmodule

`default_nettype wire

### src/cbm_decode.sv
// Address decode for one bus access: region, physical offset, store enable and data.
// Depends on cbm_pkg; purely combinational.
`default_nettype none

module cbm_decode (
	input  wire cbm_pkg::access_t     acc,
	input  wire cbm_pkg::bank_state_t state,
	output cbm_pkg::result_t          res
);

	logic [cbm_pkg::ADDR_WIDTH-1:0] addr;
	logic                           wr;
	logic                           mapped;
	cbm_pkg::region_t               region;
	logic [cbm_pkg::OFFS_WIDTH-1:0] offset;

	assign addr = acc.address;
	assign wr   = acc.command;

	always_comb begin
		mapped = 1'b1;
		region = cbm_pkg::REGION_OPEN;
		offset = '0;
		if (addr[15:14] == 2'b00) begin
			region = cbm_pkg::REGION_ROM;
			offset = {6'd0, addr};
		end else if (addr[15:14] == 2'b01) begin
			region = cbm_pkg::REGION_ROM;
			offset = {state.rom_bank, addr[13:0]};
		end else if (addr[15:13] == 3'b100) begin
			region = cbm_pkg::REGION_VRAM;
			offset = {9'd0, addr[12:0]};
		end else if (addr[15:13] == 3'b101) begin
			if (state.ram_enable) begin
				region = cbm_pkg::REGION_CRAM;
				offset = {7'd0, state.ram_bank, addr[12:0]};
			end else begin
				mapped = 1'b0;
			end
		end else if (addr[15:13] == 3'b110) begin
			region = cbm_pkg::REGION_WRAM;
			offset = {9'd0, addr[12:0]};
		end else if (addr >= cbm_pkg::OAM_BASE && addr <= cbm_pkg::OAM_LAST) begin
			region = cbm_pkg::REGION_OAM;
			offset = {14'd0, addr[7:0]};
		end else if (addr >= cbm_pkg::IO_BASE && addr <= cbm_pkg::IO_LAST) begin
			region = cbm_pkg::REGION_IO;
			offset = {15'd0, addr[6:0]};
		end else if (addr >= cbm_pkg::HRAM_BASE && addr <= cbm_pkg::HRAM_LAST) begin
			region = cbm_pkg::REGION_HRAM;
			offset = {15'd0, addr[6:0]};
		end else if (addr == cbm_pkg::IE_ADDR) begin
			region = cbm_pkg::REGION_IE;
		end else begin
			mapped = 1'b0;
		end
	end

	always_comb begin
		if (wr && !addr[15]) begin
			res.region       = cbm_pkg::REGION_CTRL;
			res.offset       = '0;
			res.write_enable = 1'b0;
			res.out_data     = '0;
		end else if (!mapped) begin
			res.region       = cbm_pkg::REGION_OPEN;
			res.offset       = '0;
			res.write_enable = 1'b0;
			res.out_data     = wr ? '0 : cbm_pkg::OPEN_BUS_BYTE;
		end else begin
			res.region       = region;
			res.offset       = offset;
			res.write_enable = wr;
			res.out_data     = wr ? acc.write_data : '0;
		end
	end

endmodule

`default_nettype wire

### src/cartridge_bank_mapper_top.sv
// Top level of the cartridge bank mapper: input register, decode, result register.
// Depends on cbm_pkg, cbm_regs and cbm_decode.
//
// Each bus access is registered, decoded against the current mapper registers and
// held in a result register, from which it is presented on the output; a new item is
// taken every cycle while the output side keeps up. A control write updates the bank
// registers as it leaves the input register, so the next access is already translated
// with the new bank. The cartridge type is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while no access is in flight, as the block itself does
// not enforce this.
`default_nettype none

module cartridge_bank_mapper_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // address[15:0], write_data[23:16]
	input  wire logic        s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // offset[21:0], write_enable[22], out_data[30:23], zero[31]
	output logic [3:0]       m_tuser   // region
);

	cbm_pkg::access_t     acc_s1;
	logic                 valid_s1;
	cbm_pkg::result_t     res_s2;
	logic                 valid_s2;
	cbm_pkg::result_t     res_comb;
	cbm_pkg::bank_state_t state;
	logic                 s2_ready;
	logic                 adv_s1;
	logic                 in_acc;

	assign s2_ready = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && s2_ready;
	assign s_tready = !valid_s1 || s2_ready;
	assign in_acc   = s_tvalid && s_tready;

	cbm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.upd_en      (adv_s1),
		.acc         (acc_s1),
		.state       (state)
	);

	cbm_decode u_decode (
		.acc   (acc_s1),
		.state (state),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_s1.command    <= s_tuser;
			acc_s1.address    <= s_tdata[15:0];
			acc_s1.write_data <= s_tdata[23:16];
		end
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.region;
	assign m_tdata  = {1'b0, res_s2.out_data, res_s2.write_enable, res_s2.offset};

endmodule

`default_nettype wire
